/* hdl/ufr_pkg.sv */
// shared constants, codes and types for the frame receiver
`timescale 1ns / 1ps
`default_nettype none

package ufr_pkg;

  localparam int MAX_BODY  = 64;
  localparam int ADDR_W    = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;
  localparam int POS_W     = ($clog2(MAX_BODY + 4) > 7) ? $clog2(MAX_BODY + 4) : 7;
  localparam int MIN_BODY  = 4;

  localparam int BYTE_W    = 8;
  localparam int BLEN_W    = 7;
  localparam int RIDX_W    = 6;
  localparam int CFG_IDX_W = 3;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 8;

  // request kinds
  localparam logic REQ_RECEIVE = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BODY_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_CHECK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID = 3'd4;

  // register reset values
  localparam logic [BLEN_W-1:0] RESET_BODY_LENGTH = 7'd40;
  localparam logic [BYTE_W-1:0] RESET_SYNC_FIRST  = 8'd181;
  localparam logic [BYTE_W-1:0] RESET_SYNC_SECOND = 8'd98;
  localparam logic              RESET_ID_CHECK    = 1'b1;
  localparam logic [BYTE_W-1:0] RESET_EXPECTED_ID = 8'd18;

  typedef struct packed {
    logic [BLEN_W-1:0] body_length;
    logic [BYTE_W-1:0] sync_first;
    logic [BYTE_W-1:0] sync_second;
    logic              id_check_enable;
    logic [BYTE_W-1:0] expected_id;
  } cfg_t;

  // parser result for one received word
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              frame_good;
  } parse_t;

endpackage

`default_nettype wire

/* hdl/ubx_frame_receiver.sv */
// top level of the framed byte stream receiver with body read-back
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: rx_byte, read_index; tuser: req_type
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: read_data; tuser: frame_good
//  cfg       in   cfg_we                       cfg_index, cfg_data
//
// one word is accepted per cycle while s_axis_tready is high; each word gives one result,
// registered first by the read of the body ram and then by the output register.
// rst is synchronous and clears the receive state, pipeline valids and config registers.
// a stalled output holds its word; input stalls only when both stages are full.
`timescale 1ns / 1ps
`default_nettype none

module ubx_frame_receiver (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [ufr_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // rx_byte, read_index, zero pad
  input  wire logic                              s_axis_tuser,  // req_type
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic      [ufr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // read_data
  output logic                                   m_axis_tuser,  // frame_good
  input  wire logic                              cfg_we,
  input  wire logic [ufr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ufr_pkg::BYTE_W-1:0]        cfg_data
);

  localparam int PW = ufr_pkg::POS_W;

  ufr_pkg::cfg_t   cfg;
  ufr_pkg::parse_t parse;

  logic                        accept;
  logic                        out_free;
  logic                        advance;
  logic [ufr_pkg::BYTE_W-1:0]  rx_byte;
  logic [ufr_pkg::RIDX_W-1:0]  read_index;
  logic [PW-1:0]               read_index_ext;
  logic                        rd_in_range;
  logic                        is_read;
  logic                        is_receive;
  logic [ufr_pkg::BYTE_W-1:0]  rd_data;

  // middle stage, lines up with the ram read
  logic valid_p;
  logic read_p;
  logic good_p;

  assign rx_byte        = s_axis_tdata[7:0];
  assign read_index     = s_axis_tdata[13:8];
  assign read_index_ext = PW'(read_index);
  assign rd_in_range    = read_index_ext < PW'(ufr_pkg::MAX_BODY);
  assign is_read        = (s_axis_tuser == ufr_pkg::REQ_READ);
  assign is_receive     = (s_axis_tuser == ufr_pkg::REQ_RECEIVE);

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !valid_p || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign advance       = valid_p && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.body_length     <= ufr_pkg::RESET_BODY_LENGTH;
      cfg.sync_first      <= ufr_pkg::RESET_SYNC_FIRST;
      cfg.sync_second     <= ufr_pkg::RESET_SYNC_SECOND;
      cfg.id_check_enable <= ufr_pkg::RESET_ID_CHECK;
      cfg.expected_id     <= ufr_pkg::RESET_EXPECTED_ID;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ufr_pkg::CFG_BODY_LENGTH: cfg.body_length     <= cfg_data[ufr_pkg::BLEN_W-1:0];
        ufr_pkg::CFG_SYNC_FIRST:  cfg.sync_first      <= cfg_data;
        ufr_pkg::CFG_SYNC_SECOND: cfg.sync_second     <= cfg_data;
        ufr_pkg::CFG_ID_CHECK:    cfg.id_check_enable <= cfg_data[0];
        ufr_pkg::CFG_EXPECTED_ID: cfg.expected_id     <= cfg_data;
        default: ;
      endcase
    end
  end

  ufr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (accept && is_receive),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .res     (parse)
  );

  ufr_ram #(
    .WIDTH (ufr_pkg::BYTE_W),
    .DEPTH (ufr_pkg::MAX_BODY)
  ) u_body_ram (
    .clk     (clk),
    .wr_en   (parse.wr_en),
    .wr_addr (parse.wr_addr),
    .wr_data (rx_byte),
    .rd_en   (accept && is_read),
    .rd_addr (read_index_ext[ufr_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_p       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        valid_p <= 1'b1;
      end else if (advance) begin
        valid_p <= 1'b0;
      end
      if (advance) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (accept) begin
      read_p <= is_read && rd_in_range;
      good_p <= parse.frame_good;
    end
    if (advance) begin
      m_axis_tdata <= read_p ? rd_data : '0;
      m_axis_tuser <= good_p;
    end
  end

`ifndef ASSERT_OFF
  // a good frame flag never comes with read data
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("frame_good raised with nonzero read data");

  // input only stalls when both stages are full and the output is blocked
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (valid_p && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

  // an accepted word always fills the middle stage
  assert property (@(posedge clk) disable iff (rst)
    accept |=> valid_p)
    else $error("accepted word lost before the middle stage");
`endif

endmodule

`default_nettype wire

/* hdl/ufr_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module ufr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                       wr_data,
  input  wire logic                                   rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/ufr_parser.sv */
// sync hunt, position tracking and 8-bit fletcher-style checksum (sums modulo 256) for the byte stream
`timescale 1ns / 1ps
`default_nettype none

module ufr_parser (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       step,
  input  wire logic [ufr_pkg::BYTE_W-1:0] rx_byte,
  input  wire ufr_pkg::cfg_t              cfg,
  output ufr_pkg::parse_t                 res
);

  localparam int PW = ufr_pkg::POS_W;
  localparam logic [PW-1:0] MIN_LEN = PW'(ufr_pkg::MIN_BODY);
  localparam logic [PW-1:0] MAX_LEN = PW'(ufr_pkg::MAX_BODY);
  localparam logic [PW-1:0] POS_ONE = PW'(1);
  localparam logic [PW-1:0] POS_TWO = PW'(2);
  localparam logic [PW-1:0] POS_THREE = PW'(3);

  logic [PW-1:0]              pos, pos_next;
  logic [ufr_pkg::BYTE_W-1:0] sum_a, sum_a_next;
  logic [ufr_pkg::BYTE_W-1:0] sum_b, sum_b_next;

  logic [PW-1:0]              len_raw, len;
  logic [PW-1:0]              body_idx;
  logic                       in_body;
  logic [ufr_pkg::BYTE_W-1:0] add_a, add_b;

  always_comb begin
    len_raw = PW'(cfg.body_length);
    if (len_raw < MIN_LEN) begin
      len = MIN_LEN;
    end else if (len_raw > MAX_LEN) begin
      len = MAX_LEN;
    end else begin
      len = len_raw;
    end
  end

  assign body_idx = pos - POS_TWO;
  assign in_body  = (pos >= POS_TWO) && (body_idx < len);
  assign add_a    = sum_a + rx_byte;
  assign add_b    = sum_b + add_a;

  always_comb begin
    pos_next       = pos;
    sum_a_next     = sum_a;
    sum_b_next     = sum_b;
    res.wr_en      = 1'b0;
    res.wr_addr    = body_idx[ufr_pkg::ADDR_W-1:0];
    res.frame_good = 1'b0;
    if (step) begin
      if (pos == '0) begin
        pos_next = (rx_byte == cfg.sync_first) ? POS_ONE : '0;
      end else if (pos == POS_ONE) begin
        if (rx_byte == cfg.sync_second) begin
          pos_next   = POS_TWO;
          sum_a_next = '0;
          sum_b_next = '0;
        end else begin
          pos_next = '0;
        end
      end else if (in_body) begin
        res.wr_en  = 1'b1;
        sum_a_next = add_a;
        sum_b_next = add_b;
        // wrong message id restarts the hunt
        if (body_idx == POS_ONE && cfg.id_check_enable && rx_byte != cfg.expected_id) begin
          pos_next = '0;
        end else begin
          pos_next = pos + POS_ONE;
        end
      end else if (pos == len + POS_TWO) begin
        pos_next = (rx_byte == sum_a) ? pos + POS_ONE : '0;
      end else begin
        pos_next       = '0;
        res.frame_good = (pos == len + POS_THREE) && (rx_byte == sum_b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      sum_a <= '0;
      sum_b <= '0;
    end else begin
      pos   <= pos_next;
      sum_a <= sum_a_next;
      sum_b <= sum_b_next;
    end
  end

endmodule

`default_nettype wire
